FILE: rtl/crst_pkg.sv
package crst_pkg;

    // field widths of one request and one result
    localparam int ID_W     = 29;
    localparam int TAG_W    = 8;
    localparam int CTX_W    = 16;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;
    localparam int TDATA_W  = 128;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    // command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADARG = 2'd2;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] handler;
        logic [CTX_W-1:0] ctx;
    } t_entry;

    // request tdata, lowest field last
    typedef struct packed {
        logic [6:0]        pad;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [CTX_W-1:0]  ctx;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
    } t_in_data;

    // result tdata, lowest field last
    typedef struct packed {
        logic [6:0]        pad;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   id;
        logic [CTX_W-1:0]  ctx;
        logic [TAG_W-1:0]  handler;
    } t_out_data;

    typedef struct packed {
        logic                hit;
        logic [STATUS_W-1:0] status;
    } t_out_user;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic search_step;
        logic write_entry;
        logic shift_step;
        logic dec_count;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             in_null;
        logic             hit_now;
        logic             exhausted;
        logic             out_free;
    } t_dp_stat;

endpackage

FILE: rtl/crst_ram.sv
module crst_ram #(
    parameter int WIDTH  = 53,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/crst_ctrl.sv
module crst_ctrl
    import crst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CMD_W-1:0] r_cmd;
    logic             accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_item = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_stat.in_cmd == CMD_REGISTER && i_stat.in_null) ||
                        (i_stat.in_cmd != CMD_REGISTER &&
                         i_stat.in_cmd != CMD_UNREGISTER &&
                         i_stat.in_cmd != CMD_DISPATCH)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.hit_now || i_stat.exhausted) begin
                    case (r_cmd)
                        CMD_REGISTER:   n_state = S_WRITE;
                        CMD_UNREGISTER: n_state = i_stat.hit_now ? S_SHIFT : S_RESULT;
                        default:        n_state = S_RESULT;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state = S_RESULT;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.exhausted) begin
                    o_cmd.dec_count = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_stat.in_cmd;
        end
    end

endmodule

FILE: rtl/crst_dp.sv
module crst_dp
    import crst_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CMD_W-1:0]   i_in_user,
    input  logic [TDATA_W-1:0] i_in_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_out_user,
    output logic [TDATA_W-1:0] o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_in_data   in_item;
    t_entry     rd_entry;
    t_entry     wr_entry;
    logic       we;
    logic [AW-1:0] waddr;

    // latched request
    logic [CMD_W-1:0]  r_cmd;
    logic              r_null;
    logic              r_full;
    logic [ID_W-1:0]   r_id;
    logic [TAG_W-1:0]  r_tag;
    logic [CTX_W-1:0]  r_ctx;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_data;

    // table walk
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_issue;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_found;
    logic [AW-1:0] r_pos;
    t_entry        r_match;

    // result register
    logic          r_out_valid;
    t_out_user     r_out_user;
    t_out_data     r_out_data;
    t_out_user     n_out_user;
    t_out_data     n_out_data;
    logic [LEN_W-1:0] len_sat;

    assign in_item = t_in_data'(i_in_data);

    assign o_stat.in_cmd    = i_in_user;
    assign o_stat.in_null   = (in_item.tag == '0);
    assign o_stat.hit_now   = r_pend && (rd_entry.id == r_id);
    assign o_stat.exhausted = !r_pend && (r_issue >= r_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    crst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_entry),
        .i_raddr(r_issue[AW-1:0]),
        .o_rdata(rd_entry)
    );

    // writes: entry update or append, or one step of the shift-down
    always_comb begin
        we       = 1'b0;
        waddr    = r_found ? r_pos : r_count[AW-1:0];
        wr_entry = '{id: r_id, handler: r_tag, ctx: r_ctx};
        if (i_cmd.shift_step) begin
            we       = r_pend;
            waddr    = r_pend_idx - AW'(1);
            wr_entry = rd_entry;
        end else if (i_cmd.write_entry) begin
            we = r_found || !r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_in_user;
            r_null <= (in_item.tag == '0);
            r_full <= (r_count >= DEPTH_C);
            r_id   <= in_item.id;
            r_tag  <= in_item.tag;
            r_ctx  <= in_item.ctx;
            r_len  <= in_item.len;
            r_data <= in_item.data;
        end
        if (i_cmd.search_step && o_stat.hit_now) begin
            r_pos   <= r_pend_idx;
            r_match <= rd_entry;
        end
        if ((i_cmd.search_step || i_cmd.shift_step) && !o_stat.hit_now &&
            r_issue < r_count) begin
            r_pend_idx <= r_issue[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_issue <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_issue <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.search_step && o_stat.hit_now) begin
                // restart the walk just above the match for a shift-down
                r_found <= 1'b1;
                r_issue <= CW'(r_pend_idx) + CW'(1);
                r_pend  <= 1'b0;
            end else if (i_cmd.search_step || i_cmd.shift_step) begin
                if (r_issue < r_count) begin
                    r_pend  <= 1'b1;
                    r_issue <= r_issue + CW'(1);
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.write_entry && !r_found && !r_full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // result build
    assign len_sat = (r_len > MAX_LEN) ? MAX_LEN : r_len;

    always_comb begin
        n_out_user = '0;
        n_out_data = '0;
        case (r_cmd)
            CMD_REGISTER: begin
                if (r_null) begin
                    n_out_user.status = ST_BADARG;
                end else if (!r_found && r_full) begin
                    n_out_user.status = ST_FULL;
                end else begin
                    n_out_user.status = ST_OK;
                end
            end
            CMD_DISPATCH: begin
                if (r_found) begin
                    n_out_user.hit     = 1'b1;
                    n_out_data.handler = r_match.handler;
                    n_out_data.ctx     = r_match.ctx;
                    n_out_data.id      = r_id;
                    n_out_data.len     = len_sat;
                    for (int b = 0; b < 8; b++) begin
                        if (LEN_W'(b) < len_sat) begin
                            n_out_data.data[b*8 +: 8] = r_data[b*8 +: 8];
                        end
                    end
                end
            end
            default: begin
                n_out_user = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_user <= n_out_user;
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_user;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above table depth");

    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dec_count |-> (r_count != '0 && r_found))
        else $error("entry removed without a match");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_step && r_pend) |-> (CW'(r_pend_idx) < r_count &&
                                          r_pend_idx != '0))
        else $error("shift step outside valid entries");

endmodule

FILE: rtl/can_rx_subscription_table_top.sv
// channel   dir  handshake                      payload
// request   in   s_axis_tvalid / s_axis_tready  tuser: command; tdata: id, tag, ctx, len, data
// result    out  m_axis_tvalid / m_axis_tready  tuser: status, hit; tdata: handler..data
//
// one request at a time; the table in ram is walked one entry per cycle
// states per request: idle, search, write (register), shift (unregister on a hit), result
// a null register and command 3 skip search, write and shift and go straight to result
// a stalled result holds the controller in its result state; reset clears the entry count,
// walk state, result valid and controller state, but not the ram
module can_rx_subscription_table_top
    import crst_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CMD_W-1:0]   s_axis_tuser,  // [1:0] command
    input  logic [TDATA_W-1:0] s_axis_tdata,  // [28:0] frame_id, [36:29] handler_tag,
                                              // [52:37] handler_context, [56:53] frame_length,
                                              // [120:57] frame_data, rest zero
    // result
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [2:0]         m_axis_tuser,  // [1:0] status, [2] hit
    output logic [TDATA_W-1:0] m_axis_tdata   // [7:0] out_handler, [23:8] out_context,
                                              // [52:24] out_id, [56:53] out_length,
                                              // [120:57] out_data, rest zero
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: search, write, shift-down and result hand-off
    crst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // table ram, walk pointers, entry count and result register
    crst_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_in_user  (s_axis_tuser),
        .i_in_data  (s_axis_tdata),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_user (m_axis_tuser),
        .o_out_data (m_axis_tdata)
    );

endmodule
